// File: hdl/line_follow_pid_steering_unit_assert.svh
// Assertion macros for the line follower steering unit checker.
`ifndef LINE_FOLLOW_PID_STEERING_UNIT_ASSERT_SVH
`define LINE_FOLLOW_PID_STEERING_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define LFPS_ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("lfps assertion failed");

// Next-cycle implication, off while reset is asserted.
`define LFPS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("lfps assertion failed");

`endif

// File: hdl/lfps_pkg.sv
// Shared types and constants of the line follower steering unit.
`default_nettype none
package lfps_pkg;

    localparam int GAIN_W            = 12;
    localparam int PWM_W             = 8;
    localparam int SENSOR_W          = 8;
    localparam int PULSE_W           = 2;
    localparam int JCOUNT_W          = 2;
    localparam int ERR_W             = 9;
    localparam int MAG_W             = 10;
    localparam int GAIN_FRAC_BITS    = 4;
    localparam int SUM_WIDTH_DEFAULT = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = 2;
    localparam int OUT_COUNT_W = 3;

    localparam logic [SENSOR_W-1:0] NO_LINE    = 8'd255;
    localparam logic [PWM_W-1:0]    STRAFE_PWM = 8'd150;
    localparam logic [PWM_W-1:0]    PWM_MAX    = 8'd255;
    localparam logic [PWM_W-1:0]    PWM_ZERO   = 8'd0;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RESET     = 12'd80;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RESET    = 12'd48;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RESET    = 12'd0;
    localparam logic [PWM_W-1:0]  LINE_MIDPOINT_RESET = 8'd35;
    localparam logic [PWM_W-1:0]  BASE_SPEED_RESET    = 8'd200;

    typedef enum logic [1:0] {
        MOTION_STEER  = 2'd0,
        MOTION_NUDGE  = 2'd1,
        MOTION_STRAFE = 2'd2,
        MOTION_STOP   = 2'd3
    } t_motion;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PROP_GAIN     = 3'd0,
        CFG_DERIV_GAIN    = 3'd1,
        CFG_INTEG_GAIN    = 3'd2,
        CFG_LINE_MIDPOINT = 3'd3,
        CFG_BASE_SPEED    = 3'd4
    } t_cfg_index;

    typedef struct packed {
        t_motion          motion;
        logic [PWM_W-1:0] left_speed;
        logic [PWM_W-1:0] right_speed;
        logic             zone_reached;
        logic             last_of_run;
    } t_result;

endpackage
`default_nettype wire

// File: hdl/lfps_if.sv
// Input and result channel interfaces of the line follower steering unit.
`default_nettype none
interface lfps_in_if import lfps_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SENSOR_W-1:0] sensor_value;
    logic [PULSE_W-1:0]  junction_pulses;

    modport source (output valid, output sensor_value, output junction_pulses, input ready);
    modport sink   (input valid, input sensor_value, input junction_pulses, output ready);
endinterface

interface lfps_out_if import lfps_pkg::*; ();
    logic             valid;
    logic             ready;
    t_motion          motion;
    logic [PWM_W-1:0] left_speed;
    logic [PWM_W-1:0] right_speed;
    logic             zone_reached;
    logic             last_of_run;

    modport source (output valid, output motion, output left_speed, output right_speed,
                    output zone_reached, output last_of_run, input ready);
    modport sink   (input valid, input motion, input left_speed, input right_speed,
                    input zone_reached, input last_of_run, output ready);
endinterface
`default_nettype wire

// File: hdl/line_follow_pid_steering_unit.sv
// Top level of the line follower PID steering unit.
//
//   channel   dir  handshake          payload
//   i_in      in   valid/ready        sensor_value, junction_pulses
//   o_out     out  valid/ready        motion, left/right_speed, zone_reached, last_of_run
//   i_cfg_*   in   write enable only  register index, write data
//
// One transaction is taken every cycle while input ready is high; its results are computed in the
// same cycle from the controller state and written to a four-entry result queue.
// A first strafe transaction gives two results, every other one gives one; the queue drains one
// result per cycle while o_out.ready is high, so throughput is one transaction per result slot.
// Input ready needs two free queue entries; an output stall backs up into ready.
// Synchronous active-low reset empties the queue and clears the controller state.
`default_nettype none
module line_follow_pid_steering_unit import lfps_pkg::*; #(
    parameter int SUM_WIDTH = SUM_WIDTH_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    lfps_in_if.sink                i_in,
    lfps_out_if.source             o_out
);

    localparam int KP_PROD_W = GAIN_W + 1 + ERR_W;
    localparam int KD_PROD_W = GAIN_W + 1 + ERR_W + 1;
    localparam int KI_PROD_W = GAIN_W + 1 + SUM_WIDTH;
    localparam int TOTAL_W   = SUM_WIDTH + 15;

    logic [GAIN_W-1:0] r_prop_gain;
    logic [GAIN_W-1:0] r_deriv_gain;
    logic [GAIN_W-1:0] r_integ_gain;
    logic [PWM_W-1:0]  r_line_midpoint;
    logic [PWM_W-1:0]  r_base_speed;

    logic signed [ERR_W-1:0]     r_prev_error;
    logic signed [SUM_WIDTH-1:0] r_error_sum;
    logic [PWM_W-1:0]            r_last_left;
    logic [JCOUNT_W-1:0]         r_junction_count;
    logic                        r_nudge_done;
    logic                        r_arrived;

    t_result                 r_out_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]    r_wr_ptr;
    logic [OUT_PTR_W-1:0]    r_rd_ptr;
    logic [OUT_COUNT_W-1:0]  r_count;

    logic                    w_in_fire;
    logic                    w_pop;
    logic [JCOUNT_W:0]       w_jc_sum;
    logic [JCOUNT_W-1:0]     n_junction_count;
    logic                    w_stop;
    logic                    w_strafe;
    logic                    w_nudge;
    logic                    w_steer;

    logic signed [ERR_W-1:0]     w_err;
    logic signed [ERR_W:0]       w_diff;
    logic signed [SUM_WIDTH:0]   w_sum_raw;
    logic signed [SUM_WIDTH-1:0] n_error_sum;
    logic signed [GAIN_W:0]      w_kp;
    logic signed [GAIN_W:0]      w_kd;
    logic signed [GAIN_W:0]      w_ki;
    logic signed [KP_PROD_W-1:0] w_p_prod;
    logic signed [KD_PROD_W-1:0] w_d_prod;
    logic signed [KI_PROD_W-1:0] w_i_prod;
    logic signed [TOTAL_W-1:0]   w_total;
    logic [TOTAL_W-1:0]          w_abs;
    logic [TOTAL_W-1:0]          w_shift;
    logic [MAG_W-1:0]            w_mag;
    logic [PWM_W+2:0]            w_up_sum;
    logic [MAG_W-1:0]            w_dn_diff;
    logic [PWM_W-1:0]            w_up_pwm;
    logic [PWM_W-1:0]            w_dn_pwm;
    logic [PWM_W-1:0]            w_left;
    logic [PWM_W-1:0]            w_right;

    t_result                w_res0;
    t_result                w_res1;
    t_result                w_head;
    logic [1:0]             w_push_n;
    logic [OUT_COUNT_W-1:0] n_count;

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_pop      = o_out.valid && o_out.ready;
    assign i_in.ready = i_rst_n && (r_count <= OUT_COUNT_W'(OUT_DEPTH - 2));

    always_comb begin
        w_jc_sum         = {1'b0, r_junction_count} + {1'b0, i_in.junction_pulses};
        n_junction_count = w_jc_sum[JCOUNT_W] ? '1 : w_jc_sum[JCOUNT_W-1:0];
        w_stop           = r_arrived || n_junction_count[JCOUNT_W-1];
        w_strafe         = !w_stop && (n_junction_count == JCOUNT_W'(1))
                           && (i_in.sensor_value == NO_LINE);
        w_nudge          = w_strafe && !r_nudge_done;
        w_steer          = !w_stop && !w_strafe;
    end

    always_comb begin
        w_err     = $signed({1'b0, i_in.sensor_value}) - $signed({1'b0, r_line_midpoint});
        w_diff    = w_err - r_prev_error;
        w_sum_raw = r_error_sum + w_err;
        if (w_sum_raw[SUM_WIDTH] != w_sum_raw[SUM_WIDTH-1]) begin
            n_error_sum = w_sum_raw[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                               : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end else begin
            n_error_sum = w_sum_raw[SUM_WIDTH-1:0];
        end
    end

    assign w_kp     = $signed({1'b0, r_prop_gain});
    assign w_kd     = $signed({1'b0, r_deriv_gain});
    assign w_ki     = $signed({1'b0, r_integ_gain});
    assign w_p_prod = w_kp * w_err;
    assign w_d_prod = w_kd * w_diff;
    assign w_i_prod = w_ki * n_error_sum;
    assign w_total  = w_p_prod + w_d_prod + w_i_prod;

    always_comb begin
        w_abs     = w_total[TOTAL_W-1] ? $unsigned(~w_total + 1'b1) : $unsigned(w_total);
        w_shift   = w_abs >> GAIN_FRAC_BITS;
        w_mag     = (|w_shift[TOTAL_W-1:MAG_W]) ? '1 : w_shift[MAG_W-1:0];
        w_up_sum  = {3'b000, r_base_speed} + {1'b0, w_mag};
        w_up_pwm  = (|w_up_sum[PWM_W+2:PWM_W]) ? PWM_MAX : w_up_sum[PWM_W-1:0];
        w_dn_diff = {2'b00, r_base_speed} - w_mag;
        w_dn_pwm  = (w_mag > {2'b00, r_base_speed}) ? PWM_ZERO : w_dn_diff[PWM_W-1:0];
        w_left    = w_err[ERR_W-1] ? w_dn_pwm : w_up_pwm;
        w_right   = w_err[ERR_W-1] ? w_up_pwm : w_dn_pwm;
    end

    always_comb begin
        w_res1 = '{motion: MOTION_STRAFE, left_speed: STRAFE_PWM, right_speed: STRAFE_PWM,
                   zone_reached: 1'b0, last_of_run: 1'b1};
        if (w_stop) begin
            w_res0 = '{motion: MOTION_STOP, left_speed: PWM_ZERO, right_speed: PWM_ZERO,
                       zone_reached: 1'b1, last_of_run: 1'b1};
        end else if (w_nudge) begin
            w_res0 = '{motion: MOTION_NUDGE, left_speed: r_last_left, right_speed: r_last_left,
                       zone_reached: 1'b0, last_of_run: 1'b0};
        end else if (w_strafe) begin
            w_res0 = w_res1;
        end else begin
            w_res0 = '{motion: MOTION_STEER, left_speed: w_left, right_speed: w_right,
                       zone_reached: 1'b0, last_of_run: 1'b1};
        end
        if (!w_in_fire) begin
            w_push_n = 2'd0;
        end else if (w_nudge) begin
            w_push_n = 2'd2;
        end else begin
            w_push_n = 2'd1;
        end
        n_count = r_count + OUT_COUNT_W'(w_push_n) - OUT_COUNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain     <= PROP_GAIN_RESET;
            r_deriv_gain    <= DERIV_GAIN_RESET;
            r_integ_gain    <= INTEG_GAIN_RESET;
            r_line_midpoint <= LINE_MIDPOINT_RESET;
            r_base_speed    <= BASE_SPEED_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:     r_prop_gain     <= i_cfg_data;
                CFG_DERIV_GAIN:    r_deriv_gain    <= i_cfg_data;
                CFG_INTEG_GAIN:    r_integ_gain    <= i_cfg_data;
                CFG_LINE_MIDPOINT: r_line_midpoint <= i_cfg_data[PWM_W-1:0];
                CFG_BASE_SPEED:    r_base_speed    <= i_cfg_data[PWM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_error     <= '0;
            r_error_sum      <= '0;
            r_last_left      <= '0;
            r_junction_count <= '0;
            r_nudge_done     <= 1'b0;
            r_arrived        <= 1'b0;
        end else if (w_in_fire) begin
            r_junction_count <= n_junction_count;
            r_arrived        <= w_stop;
            if (w_nudge) begin
                r_nudge_done <= 1'b1;
            end
            if (w_steer) begin
                r_prev_error <= w_err;
                r_error_sum  <= n_error_sum;
                r_last_left  <= w_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out_mem[r_wr_ptr] <= w_res0;
            if (w_nudge) begin
                r_out_mem[r_wr_ptr + 1'b1] <= w_res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(w_push_n);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign w_head             = r_out_mem[r_rd_ptr];
    assign o_out.valid        = (r_count != '0);
    assign o_out.motion       = w_head.motion;
    assign o_out.left_speed   = w_head.left_speed;
    assign o_out.right_speed  = w_head.right_speed;
    assign o_out.zone_reached = w_head.zone_reached;
    assign o_out.last_of_run  = w_head.last_of_run;

endmodule
`default_nettype wire

// File: hdl/lfps_checker.sv
// Port-level checker of the line follower steering unit and its bind.
`default_nettype none
`include "line_follow_pid_steering_unit_assert.svh"
module lfps_checker import lfps_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire t_motion          i_motion,
    input wire logic [PWM_W-1:0] i_left_speed,
    input wire logic [PWM_W-1:0] i_right_speed,
    input wire logic             i_zone_reached,
    input wire logic             i_last_of_run
);

    `LFPS_ASSERT_IMPLIES(a_empty_after_reset, i_clk, i_rst_n, $rose(i_rst_n), !i_out_valid)

    `LFPS_ASSERT_IMPLIES(a_stop_result, i_clk, i_rst_n, i_out_valid && (i_motion == MOTION_STOP), (i_left_speed == PWM_ZERO) && (i_right_speed == PWM_ZERO) && i_zone_reached && i_last_of_run)

    `LFPS_ASSERT_IMPLIES(a_strafe_result, i_clk, i_rst_n, i_out_valid && (i_motion == MOTION_STRAFE), (i_left_speed == STRAFE_PWM) && (i_right_speed == STRAFE_PWM) && !i_zone_reached && i_last_of_run)

    `LFPS_ASSERT_NEXT(a_nudge_then_strafe, i_clk, i_rst_n, i_out_valid && i_out_ready && (i_motion == MOTION_NUDGE), i_out_valid && (i_motion == MOTION_STRAFE))

    `LFPS_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_motion) && $stable(i_left_speed) && $stable(i_right_speed))

endmodule

bind line_follow_pid_steering_unit lfps_checker u_lfps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_motion       (o_out.motion),
    .i_left_speed   (o_out.left_speed),
    .i_right_speed  (o_out.right_speed),
    .i_zone_reached (o_out.zone_reached),
    .i_last_of_run  (o_out.last_of_run)
);
`default_nettype wire
